// File: src/cvi_pkg.sv
// shared types, constants and helpers for the cylindrical voxel index block
package cvi_pkg;

    localparam int RES_W     = 11;
    localparam int VOX_W     = 31;
    localparam int POS_W     = 32;
    localparam int IDX_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 64;

    localparam logic [RES_W-1:0] MAX_RES = 11'd1024;

    // one quotient bit or one root bit per step, 32 steps per loop
    localparam logic [4:0] LAST_STEP = 5'd31;
    localparam logic [STEP_W-1:0] SQRT_FIRST_BIT = 64'h4000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RES_X,
        REG_RES_Y,
        REG_RES_Z,
        REG_VOXEL_SIZE_X,
        REG_VOXEL_SIZE_Y,
        REG_VOXEL_SIZE_Z,
        REG_HALF_SIZE_X,
        REG_HALF_SIZE_Z
    } cfg_reg_t;

    typedef struct packed {
        logic [RES_W-1:0] res_x;
        logic [RES_W-1:0] res_y;
        logic [RES_W-1:0] res_z;
        logic [VOX_W-1:0] voxel_size_x;
        logic [VOX_W-1:0] voxel_size_y;
        logic [VOX_W-1:0] voxel_size_z;
        logic [VOX_W-1:0] half_size_x;
        logic [VOX_W-1:0] half_size_z;
    } cfg_t;

    typedef struct packed {
        logic              ge;
        logic [STEP_W-1:0] diff;
    } step_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AX_DIV,
        ST_SQ_A,
        ST_SQ_B,
        ST_SUM,
        ST_SQRT,
        ST_RAD_DIV,
        ST_RAD_FIN,
        ST_IDX_MUL,
        ST_RESULT
    } state_t;

    function automatic logic res_ok(input logic [RES_W-1:0] r);
        return (r != '0) && (r <= MAX_RES);
    endfunction

endpackage

// File: src/cvi_cfg_regs.sv
// configuration register file with write port
module cvi_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cvi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvi_pkg::VOX_W-1:0]      cfg_data,
    output cvi_pkg::cfg_t                  cfg
);

    cvi_pkg::cfg_t cfg_reg;
    cvi_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cvi_pkg::cfg_reg_t'(cfg_index))
                cvi_pkg::REG_RES_X:        cfg_next.res_x        = cfg_data[cvi_pkg::RES_W-1:0];
                cvi_pkg::REG_RES_Y:        cfg_next.res_y        = cfg_data[cvi_pkg::RES_W-1:0];
                cvi_pkg::REG_RES_Z:        cfg_next.res_z        = cfg_data[cvi_pkg::RES_W-1:0];
                cvi_pkg::REG_VOXEL_SIZE_X: cfg_next.voxel_size_x = cfg_data;
                cvi_pkg::REG_VOXEL_SIZE_Y: cfg_next.voxel_size_y = cfg_data;
                cvi_pkg::REG_VOXEL_SIZE_Z: cfg_next.voxel_size_z = cfg_data;
                cvi_pkg::REG_HALF_SIZE_X:  cfg_next.half_size_x  = cfg_data;
                cvi_pkg::REG_HALF_SIZE_Z:  cfg_next.half_size_z  = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.res_x        <= 11'd1;
            cfg_reg.res_y        <= 11'd1;
            cfg_reg.res_z        <= 11'd1;
            cfg_reg.voxel_size_x <= 31'd65536;
            cfg_reg.voxel_size_y <= 31'd65536;
            cfg_reg.voxel_size_z <= 31'd65536;
            cfg_reg.half_size_x  <= 31'd32768;
            cfg_reg.half_size_z  <= 31'd32768;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/cvi_sub_unit.sv
// shared 64-bit compare and subtract unit for division and square root steps
module cvi_sub_unit
(
    input  logic [cvi_pkg::STEP_W-1:0] a,
    input  logic [cvi_pkg::STEP_W-1:0] b,
    output cvi_pkg::step_res_t         res
);

    logic [cvi_pkg::STEP_W:0] wide;

    assign wide     = {1'b0, a} - {1'b0, b};
    assign res.ge   = ~wide[cvi_pkg::STEP_W];
    assign res.diff = wide[cvi_pkg::STEP_W-1:0];

endmodule

// File: src/cvi_mul.sv
// 32x32 unsigned multiplier, product registered by the caller
module cvi_mul
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    assign p = {32'd0, a} * {32'd0, b};

endmodule

// File: src/cylindrical_voxel_index.sv
// cylindrical voxel index: sequencer, datapath and output register
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  pos_x, pos_y, pos_z
//  output    out        out_valid/out_stall  voxel_index, inside_res
//  config    in         cfg_write            cfg_index, cfg_data
//
// an item passes from accept to result through one 32-step axial division,
// two squares, a sum, a 32-step integer root, a 32-step radial division and
// one multiply for the index; divisions and root share one compare-subtract unit
// no new item is taken until the result is in the output register
// a stalled result holds; the next item is taken while it waits
// reset clears the sequencer and the output valid and loads default geometry
module cylindrical_voxel_index
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    input  logic signed [31:0]             pos_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cvi_pkg::IDX_W-1:0]      voxel_index,
    output logic                           inside_res,
    input  logic                           cfg_write,
    input  logic [cvi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvi_pkg::VOX_W-1:0]      cfg_data
);

    cvi_pkg::cfg_t       cfg;
    cvi_pkg::state_t     state_reg;
    cvi_pkg::state_t     state_next;
    cvi_pkg::step_res_t  step;

    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        load_result;
    logic        unit_sqrt;

    // held item state
    logic        beam_x_reg;
    logic        geom_ok_reg;
    logic [31:0] ma_reg;
    logic [31:0] mb_reg;
    logic        num_neg_reg;
    logic [31:0] dq_reg;
    logic [30:0] rem_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [9:0]  ax_bin_reg;
    logic        ax_ok_reg;
    logic [8:0]  rad_bin_reg;
    logic        rad_ok_reg;
    logic [cvi_pkg::IDX_W-1:0] voxel_index_reg;
    logic        inside_reg;

    // accept-time selection
    logic        acc_beam_x;
    logic        acc_geom_ok;
    logic [31:0] ra_u;
    logic [31:0] rb_u;
    logic [31:0] ax_pos_u;
    logic [30:0] ax_half;
    logic [32:0] num_c;
    logic [31:0] ma_c;
    logic [31:0] mb_c;

    logic [cvi_pkg::RES_W-1:0] ax_res;
    logic [cvi_pkg::RES_W-1:0] rad_res;
    logic [cvi_pkg::VOX_W-1:0] ax_vox;
    logic [cvi_pkg::VOX_W-1:0] rad_vox;
    logic [cvi_pkg::VOX_W-1:0] div_vox;

    logic [63:0] unit_a;
    logic [63:0] unit_b;
    logic [63:0] root_next;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    logic        ax_border;
    logic        ax_ok_c;
    logic [9:0]  ax_bin_c;
    logic        rad_border;
    logic [31:0] rad_bin_full;
    logic        rad_ok_c;
    logic [cvi_pkg::IDX_W-1:0] idx_c;
    logic        inside_c;

    cvi_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cvi_sub_unit u_sub
    (
        .a   (unit_a),
        .b   (unit_b),
        .res (step)
    );

    cvi_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .p (prod)
    );

    // ---------------- accept-time operand selection ----------------
    always_comb
    begin
        acc_beam_x  = (cfg.res_z == 11'd1);
        acc_geom_ok = cvi_pkg::res_ok(cfg.res_x) && cvi_pkg::res_ok(cfg.res_y)
                      && cvi_pkg::res_ok(cfg.res_z)
                      && ((cfg.res_z == 11'd1) || (cfg.res_y == 11'd1));
        ra_u     = acc_beam_x ? pos_y : pos_x;
        rb_u     = acc_beam_x ? pos_z : pos_y;
        ax_pos_u = acc_beam_x ? pos_x : pos_z;
        ax_half  = acc_beam_x ? cfg.half_size_x : cfg.half_size_z;
        // bit 32 is the sign of the shifted axial position
        num_c    = {ax_pos_u[31], ax_pos_u} + {2'b00, ax_half};
        ma_c     = ra_u[31] ? (32'd0 - ra_u) : ra_u;
        mb_c     = rb_u[31] ? (32'd0 - rb_u) : rb_u;
    end

    // ---------------- per-axis geometry ----------------
    always_comb
    begin
        ax_res  = beam_x_reg ? cfg.res_x        : cfg.res_z;
        ax_vox  = beam_x_reg ? cfg.voxel_size_x : cfg.voxel_size_z;
        rad_res = beam_x_reg ? cfg.res_y        : cfg.res_x;
        rad_vox = beam_x_reg ? cfg.voxel_size_y : cfg.voxel_size_x;
        div_vox = (state_reg == cvi_pkg::ST_RAD_DIV) ? rad_vox : ax_vox;
    end

    // ---------------- shared unit operands ----------------
    always_comb
    begin
        if (unit_sqrt)
        begin
            unit_a = acc_reg;
            // root only has bits above the current trial bit
            unit_b = root_reg | bit_reg;
        end
        else
        begin
            unit_a = {32'd0, rem_reg, dq_reg[31]};
            unit_b = {33'd0, div_vox};
        end
        root_next = step.ge ? ((root_reg >> 1) | bit_reg) : (root_reg >> 1);
    end

    always_comb
    begin
        case (state_reg)
            cvi_pkg::ST_SQ_A:
            begin
                mul_a = ma_reg;
                mul_b = ma_reg;
            end
            cvi_pkg::ST_SQ_B:
            begin
                mul_a = mb_reg;
                mul_b = mb_reg;
            end
            cvi_pkg::ST_IDX_MUL:
            begin
                mul_a = beam_x_reg ? {23'd0, rad_bin_reg} : {22'd0, ax_bin_reg};
                mul_b = {21'd0, cfg.res_x};
            end
            default:
            begin
                mul_a = ma_reg;
                mul_b = mb_reg;
            end
        endcase
    end

    // ---------------- bin decisions ----------------
    always_comb
    begin
        // a hit exactly on the far border goes to the last bin
        ax_border = (dq_reg == {21'd0, ax_res}) && (rem_reg == '0);
        ax_ok_c   = !num_neg_reg && (ax_vox != '0)
                    && (ax_border || (dq_reg < {21'd0, ax_res}));
        ax_bin_c  = ax_border ? 10'(ax_res - 11'd1) : dq_reg[9:0];

        rad_border   = (dq_reg == {21'd0, rad_res}) && (rem_reg == '0);
        rad_bin_full = rad_border ? {21'd0, 11'(rad_res - 11'd1)} : dq_reg;
        rad_ok_c     = (rad_vox != '0) && ({rad_bin_full, 1'b0} < {22'd0, rad_res});

        idx_c    = prod_reg[cvi_pkg::IDX_W-1:0]
                   + (beam_x_reg ? {10'd0, ax_bin_reg} : {11'd0, rad_bin_reg});
        inside_c = geom_ok_reg && ax_ok_reg && rad_ok_reg;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvi_pkg::ST_IDLE:
                if (in_valid) state_next = cvi_pkg::ST_AX_DIV;
            cvi_pkg::ST_AX_DIV:
                if (cnt_reg == cvi_pkg::LAST_STEP) state_next = cvi_pkg::ST_SQ_A;
            cvi_pkg::ST_SQ_A:
                state_next = cvi_pkg::ST_SQ_B;
            cvi_pkg::ST_SQ_B:
                state_next = cvi_pkg::ST_SUM;
            cvi_pkg::ST_SUM:
                state_next = cvi_pkg::ST_SQRT;
            cvi_pkg::ST_SQRT:
                if (cnt_reg == cvi_pkg::LAST_STEP) state_next = cvi_pkg::ST_RAD_DIV;
            cvi_pkg::ST_RAD_DIV:
                if (cnt_reg == cvi_pkg::LAST_STEP) state_next = cvi_pkg::ST_RAD_FIN;
            cvi_pkg::ST_RAD_FIN:
                state_next = cvi_pkg::ST_IDX_MUL;
            cvi_pkg::ST_IDX_MUL:
                state_next = cvi_pkg::ST_RESULT;
            cvi_pkg::ST_RESULT:
                if (out_free) state_next = cvi_pkg::ST_IDLE;
            default:
                state_next = cvi_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = (state_reg != cvi_pkg::ST_IDLE);
        unit_sqrt   = (state_reg == cvi_pkg::ST_SQRT);
        out_free    = !out_valid_reg || !out_stall;
        load_result = (state_reg == cvi_pkg::ST_RESULT) && out_free;
        if (state_reg inside {cvi_pkg::ST_AX_DIV, cvi_pkg::ST_SQRT, cvi_pkg::ST_RAD_DIV})
            cnt_next = cnt_reg + 5'd1;
        else
            cnt_next = '0;
        if (load_result)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cvi_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cvi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    beam_x_reg  <= acc_beam_x;
                    geom_ok_reg <= acc_geom_ok;
                    ma_reg      <= ma_c;
                    mb_reg      <= mb_c;
                    num_neg_reg <= num_c[32];
                    dq_reg      <= num_c[31:0];
                    rem_reg     <= '0;
                end
            end
            cvi_pkg::ST_AX_DIV, cvi_pkg::ST_RAD_DIV:
            begin
                // restoring division, one quotient bit per cycle
                dq_reg  <= {dq_reg[30:0], step.ge};
                rem_reg <= step.ge ? step.diff[30:0] : unit_a[30:0];
            end
            cvi_pkg::ST_SQ_A:
            begin
                acc_reg    <= prod;
                ax_bin_reg <= ax_bin_c;
                ax_ok_reg  <= ax_ok_c;
            end
            cvi_pkg::ST_SQ_B:
            begin
                prod_reg <= prod;
            end
            cvi_pkg::ST_SUM:
            begin
                acc_reg  <= acc_reg + prod_reg;
                root_reg <= '0;
                bit_reg  <= cvi_pkg::SQRT_FIRST_BIT;
            end
            cvi_pkg::ST_SQRT:
            begin
                if (step.ge) acc_reg <= step.diff;
                root_reg <= root_next;
                bit_reg  <= bit_reg >> 2;
                if (cnt_reg == cvi_pkg::LAST_STEP)
                begin
                    dq_reg  <= root_next[31:0];
                    rem_reg <= '0;
                end
            end
            cvi_pkg::ST_RAD_FIN:
            begin
                rad_bin_reg <= rad_bin_full[8:0];
                rad_ok_reg  <= rad_ok_c;
            end
            cvi_pkg::ST_IDX_MUL:
            begin
                prod_reg <= prod;
            end
            cvi_pkg::ST_RESULT:
            begin
                if (load_result)
                begin
                    voxel_index_reg <= inside_c ? idx_c : '0;
                    inside_reg      <= inside_c;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign voxel_index = voxel_index_reg;
    assign inside_res  = inside_reg;

endmodule

// File: src/cvi_checker.sv
// port-level checks for the cylindrical voxel index block, bound to the top level
module cvi_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [cvi_pkg::IDX_W-1:0]      voxel_index,
    input logic                           inside_res
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(voxel_index) && $stable(inside_res))
        else $error("stalled result changed");

    // an outside result carries a zero index
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> voxel_index == '0)
        else $error("outside result with nonzero index");

    // the block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("new item taken during computation");

endmodule

bind cylindrical_voxel_index cvi_checker u_cvi_checker (.*);
